### design/sdasc_pkg.sv
// shared constants and request codes for the scaled decimal add, subtract and compare block
package sdasc_pkg;

    localparam int OPERAND_BITS_DEF = 96;
    localparam int MAG_LOW_W        = 64;
    localparam int MAG_HIGH_W       = 32;
    localparam int SCALE_W          = 5;
    localparam int REQ_W            = 3;
    localparam int WORD_W           = 64;
    localparam int RESULT_W         = 3 * WORD_W;

    // 10^28 needs just under 94 bits, so alignment grows a magnitude by at most this much
    localparam int ALIGN_GROWTH     = 94;

    localparam logic [SCALE_W-1:0] MAX_SCALE = SCALE_W'(28);

    // s_tdata layout
    localparam int IN_DATA_W  = 208;
    // m_tdata layout
    localparam int OUT_DATA_W = 200;

    localparam logic [REQ_W-1:0] REQ_ADD     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SUB     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_GREATER = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LESS    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_EQUAL   = 3'd4;

    function automatic logic [SCALE_W-1:0] sat_scale(input logic [SCALE_W-1:0] s);
        sat_scale = (s > MAX_SCALE) ? MAX_SCALE : s;
    endfunction

endpackage

### design/scaled_decimal_add_sub_compare.sv
// scaled decimal add, subtract and compare with iterative times-ten alignment
//
// Each operand is a sign, a magnitude and a power-of-ten scale (0 to 28, larger scales
// are taken as 28). Add, subtract, greater and less first align the scales by multiplying
// the magnitude with the smaller scale by ten, one step per cycle, on a single shared wide
// adder; the same adder then does the magnitude compare and the sign-magnitude add or
// subtract. Equal compares sign, scale and magnitude exactly with no alignment. The block
// takes one beat at a time: add and subtract pass through align, compare and arith,
// greater and less through align and compare, equal through compare alone and unknown
// request codes straight to done, the align state looping once per times-ten step. A finished
// result sits in the output register while the next beat is accepted. Zero results may
// carry a negative sign. Magnitude bits at or above OPERAND_BITS are ignored.
module scaled_decimal_add_sub_compare #(
    parameter int OPERAND_BITS = sdasc_pkg::OPERAND_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // a_mag_low, a_mag_high, a_scale, a_negative, b_mag_low, b_mag_high, b_scale,
    // b_negative, zero pad
    input  logic [sdasc_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type
    input  logic [sdasc_pkg::REQ_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // sum_word0, sum_word1, sum_word2, sum_scale, sum_negative, truth, zero pad
    output logic [sdasc_pkg::OUT_DATA_W-1:0] m_tdata
);
    import sdasc_pkg::*;

    localparam int WORK_W = OPERAND_BITS + ALIGN_GROWTH + 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ALIGN = 5'b00010,
        ST_CMP   = 5'b00100,
        ST_ARITH = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [WORK_W-1:0]       a_reg, a_next;
    logic [WORK_W-1:0]       b_reg, b_next;
    logic [SCALE_W-1:0]      sa_reg, sa_next;
    logic [SCALE_W-1:0]      sb_reg, sb_next;
    logic                    na_reg, na_next;
    logic                    nb_reg, nb_next;
    logic [REQ_W-1:0]        op_reg, op_next;
    logic                    lt_reg, lt_next;
    logic                    eq_reg, eq_next;
    logic                    sign_reg, sign_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // input field slices
    logic [MAG_LOW_W+MAG_HIGH_W-1:0] in_a_mag, in_b_mag;
    logic [SCALE_W-1:0]              in_a_scale, in_b_scale;
    logic                            in_a_neg, in_b_neg;

    assign in_a_mag   = s_tdata[95:0];
    assign in_a_scale = s_tdata[100:96];
    assign in_a_neg   = s_tdata[101];
    assign in_b_mag   = s_tdata[197:102];
    assign in_b_scale = s_tdata[202:198];
    assign in_b_neg   = s_tdata[203];

    // shared wide adder
    logic [WORK_W-1:0] add_x, add_y;
    logic              add_cin;
    logic [WORK_W:0]   add_full;
    logic [WORK_W-1:0] align_src;
    logic              align_a;
    logic              eff_nb;
    logic              gt_flag;
    logic              truth;
    logic              out_free;

    assign align_a = (sa_reg < sb_reg);
    assign align_src = align_a ? a_reg : b_reg;
    assign eff_nb  = nb_reg ^ (op_reg == REQ_SUB);
    assign gt_flag = !lt_reg && !eq_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_cin = 1'b0;
        unique case (state_reg)
            ST_ALIGN:
            begin
                // x*10 = x*8 + x*2
                add_x = align_src << 3;
                add_y = align_src << 1;
            end
            ST_CMP:
            begin
                add_x   = a_reg;
                add_y   = ~b_reg;
                add_cin = 1'b1;
            end
            ST_ARITH:
            begin
                if (na_reg == eff_nb)
                begin
                    add_x = a_reg;
                    add_y = b_reg;
                end
                else if (lt_reg)
                begin
                    add_x   = b_reg;
                    add_y   = ~a_reg;
                    add_cin = 1'b1;
                end
                else
                begin
                    add_x   = a_reg;
                    add_y   = ~b_reg;
                    add_cin = 1'b1;
                end
            end
            default:
            begin
                add_x   = '0;
                add_y   = '0;
                add_cin = 1'b0;
            end
        endcase
    end

    assign add_full = {1'b0, add_x} + {1'b0, add_y} + {{WORK_W{1'b0}}, add_cin};

    always_comb
    begin
        case (op_reg)
            REQ_GREATER: truth = (na_reg != nb_reg) ? !na_reg : (na_reg ? lt_reg : gt_flag);
            REQ_LESS:    truth = (na_reg != nb_reg) ? na_reg : (na_reg ? gt_flag : lt_reg);
            REQ_EQUAL:   truth = (na_reg == nb_reg) && (sa_reg == sb_reg) && eq_reg;
            default:     truth = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        sa_next       = sa_reg;
        sb_next       = sb_reg;
        na_next       = na_reg;
        nb_next       = nb_reg;
        op_next       = op_reg;
        lt_next       = lt_reg;
        eq_next       = eq_reg;
        sign_next     = sign_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    a_next  = WORK_W'(in_a_mag[OPERAND_BITS-1:0]);
                    b_next  = WORK_W'(in_b_mag[OPERAND_BITS-1:0]);
                    sa_next = sat_scale(in_a_scale);
                    sb_next = sat_scale(in_b_scale);
                    na_next = in_a_neg;
                    nb_next = in_b_neg;
                    op_next = s_tuser;
                    if (s_tuser > REQ_EQUAL)
                        state_next = ST_DONE;
                    else if (s_tuser == REQ_EQUAL)
                        state_next = ST_CMP;
                    else
                        state_next = ST_ALIGN;
                end
            end
            ST_ALIGN:
            begin
                if (align_a)
                begin
                    a_next  = add_full[WORK_W-1:0];
                    sa_next = sa_reg + SCALE_W'(1);
                end
                else if (sb_reg < sa_reg)
                begin
                    b_next  = add_full[WORK_W-1:0];
                    sb_next = sb_reg + SCALE_W'(1);
                end
                else
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                // carry out low means a borrow, so a < b
                lt_next = !add_full[WORK_W];
                eq_next = (add_full[WORK_W-1:0] == '0);
                if (op_reg == REQ_ADD || op_reg == REQ_SUB)
                    state_next = ST_ARITH;
                else
                    state_next = ST_DONE;
            end
            ST_ARITH:
            begin
                if (na_reg == eff_nb)
                begin
                    a_next    = add_full[WORK_W-1:0];
                    sign_next = na_reg;
                end
                else if (lt_reg)
                begin
                    a_next    = add_full[WORK_W-1:0];
                    sign_next = eff_nb;
                end
                else if (!eq_reg)
                begin
                    a_next    = add_full[WORK_W-1:0];
                    sign_next = na_reg;
                end
                else
                begin
                    // equal magnitudes of differing sign cancel to a signed zero
                    a_next    = '0;
                    sign_next = (op_reg == REQ_SUB) ? 1'b1 : !na_reg;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    if (op_reg == REQ_ADD || op_reg == REQ_SUB)
                    begin
                        m_tdata_next[RESULT_W-1:0]                 = RESULT_W'(a_reg);
                        m_tdata_next[RESULT_W+SCALE_W-1:RESULT_W]  = sa_reg;
                        m_tdata_next[RESULT_W+SCALE_W]             = sign_reg;
                    end
                    m_tdata_next[RESULT_W+SCALE_W+1] = truth;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        sa_reg      <= sa_next;
        sb_reg      <= sb_next;
        na_reg      <= na_next;
        nb_reg      <= nb_next;
        op_reg      <= op_next;
        lt_reg      <= lt_next;
        eq_reg      <= eq_next;
        sign_reg    <= sign_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // one beat at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat accepted while busy");

    // a true compare never carries a magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[RESULT_W+SCALE_W+1] |-> m_tdata[RESULT_W-1:0] == '0)
        else $error("compare result with nonzero magnitude");

    // alignment never runs past the largest scale
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[RESULT_W+SCALE_W-1:RESULT_W] <= MAX_SCALE)
        else $error("result scale out of range");

    // a new result is only loaded once the last one has been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("pending result overwritten");

endmodule
